FILE: hw/rtl/dlr_pkg.sv
package dlr_pkg;

  localparam int COORD_BITS = 16;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int ACC_W      = 20;
  localparam int PITCH_W    = 10;
  localparam int MASK_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int PAGE_BLOCKS = 1024;
  localparam int BLOCK_BYTES = 512;
  localparam logic [ADDR_W-1:0] PAGE_LIMIT = ADDR_W'(PAGE_BLOCKS * BLOCK_BYTES);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REG_PATTERN_MASK   = 1'b0;
  localparam logic REG_BYTES_PER_LINE = 1'b1;

  localparam logic [MASK_W-1:0]  PATTERN_MASK_RESET   = 16'hFFFF;
  localparam logic [PITCH_W-1:0] BYTES_PER_LINE_RESET = 10'd264;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic              on_page;
    logic [2:0]        bit_position;
    logic [ADDR_W-1:0] byte_address;
    logic              plot;
    coord_t            pixel_y;
    coord_t            pixel_x;
  } pixel_word_t;

endpackage

FILE: hw/rtl/dashed_line_rasterizer_unit.sv
// Dashed line rasterizer.
// Input stream (s_*): one word per command. s_tuser is the command: start
// loads the endpoints carried in s_tdata, step asks for the next pixel.
// Output stream (m_*): one word per pixel, with m_tlast on the end point.
// A start word and a step word taken while no line is active give no output.
// A step word's pixel is registered and shows on m_* in the cycle after the
// word is accepted. Throughput: one word per cycle while m_tready is high;
// the walk update and the address multiply each fit between the input
// handshake and the output register.
// The APB port holds the dash mask at address 0 and the line pitch in bytes
// at address 4; write them only while no line is being drawn.
// Reset clears the walk state to idle, drops any pending pixel and restores
// the mask to solid and the pitch to 264 bytes.
// When the receiver stalls, the pixel holds in the output register and
// s_tready drops, so nothing is lost; it rises again as the pixel is taken.
module dashed_line_rasterizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, stop_x, stop_y
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // pixel_x, pixel_y, plot, byte_address,
                                 // bit_position, on_page, zero fill
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = dlr_pkg::COORD_BITS;
  localparam int SW = dlr_pkg::SPAN_W;
  localparam int AW = dlr_pkg::ACC_W;

  logic [dlr_pkg::MASK_W-1:0]  pattern_mask;
  logic [dlr_pkg::PITCH_W-1:0] bytes_per_line;

  dlr_pkg::coord_t cur_x, cur_y, end_x, end_y;
  logic [SW-1:0]   span_x, span_y;
  logic            x_backward, y_backward, x_major, busy;
  logic signed [AW-1:0] minor_accum, minor_bound;

  logic            s_fire, start_fire, step_fire, done;
  dlr_pkg::coord_t in_x0, in_y0, in_x1, in_y1;
  logic signed [SW-1:0] dx, dy;
  logic [SW-1:0]   abs_dx, abs_dy;

  dlr_pkg::coord_t cur_x_next, cur_y_next, px, py, sum;
  logic signed [AW-1:0] minor_accum_next, minor_bound_next, major_ext, minor_ext;
  logic            carry;

  logic signed [26:0] row_offset;
  logic [dlr_pkg::ADDR_W-1:0] addr;
  dlr_pkg::pixel_word_t word;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      dlr_pkg::REG_PATTERN_MASK:   prdata = 32'(pattern_mask);
      dlr_pkg::REG_BYTES_PER_LINE: prdata = 32'(bytes_per_line);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mask   <= dlr_pkg::PATTERN_MASK_RESET;
      bytes_per_line <= dlr_pkg::BYTES_PER_LINE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        dlr_pkg::REG_PATTERN_MASK:   pattern_mask   <= pwdata[dlr_pkg::MASK_W-1:0];
        dlr_pkg::REG_BYTES_PER_LINE: bytes_per_line <= pwdata[dlr_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode and line setup.
  assign s_tready   = !m_tvalid || m_tready;
  assign s_fire     = s_tvalid && s_tready;
  assign start_fire = s_fire && (s_tuser == dlr_pkg::CMD_START);
  assign step_fire  = s_fire && (s_tuser == dlr_pkg::CMD_STEP) && busy;

  assign in_x0 = s_tdata[15:0];
  assign in_y0 = s_tdata[31:16];
  assign in_x1 = s_tdata[47:32];
  assign in_y1 = s_tdata[63:48];
  assign dx = SW'(in_x1) - SW'(in_x0);
  assign dy = SW'(in_y1) - SW'(in_y0);
  assign abs_dx = dx[SW-1] ? SW'(-dx) : SW'(dx);
  assign abs_dy = dy[SW-1] ? SW'(-dy) : SW'(dy);

  // One walk step along the major axis with the error accumulator update.
  assign done = x_major ? (cur_x == end_x) : (cur_y == end_y);
  assign major_ext = x_major ? AW'(span_x) : AW'(span_y);
  assign minor_ext = x_major ? AW'(span_y) : AW'(span_x);
  assign carry     = minor_accum > minor_bound;

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    minor_bound_next = minor_bound;
    minor_accum_next = minor_accum + minor_ext;
    if (carry) begin
      minor_bound_next = minor_bound + major_ext - minor_accum;
      minor_accum_next = minor_ext;
    end
    if (x_major) begin
      cur_x_next = x_backward ? cur_x - 1'b1 : cur_x + 1'b1;
      if (carry) begin
        cur_y_next = y_backward ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end else begin
      cur_y_next = y_backward ? cur_y - 1'b1 : cur_y + 1'b1;
      if (carry) begin
        cur_x_next = x_backward ? cur_x - 1'b1 : cur_x + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      end_x       <= '0;
      end_y       <= '0;
      span_x      <= '0;
      span_y      <= '0;
      x_backward  <= 1'b0;
      y_backward  <= 1'b0;
      minor_accum <= '0;
      minor_bound <= '0;
      x_major     <= 1'b0;
      busy        <= 1'b0;
    end else if (start_fire) begin
      cur_x       <= in_x0;
      cur_y       <= in_y0;
      end_x       <= in_x1;
      end_y       <= in_y1;
      span_x      <= abs_dx;
      span_y      <= abs_dy;
      x_backward  <= dx[SW-1];
      y_backward  <= dy[SW-1];
      minor_accum <= '0;
      minor_bound <= '0;
      x_major     <= abs_dx >= abs_dy;
      busy        <= 1'b1;
    end else if (step_fire) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        cur_x       <= cur_x_next;
        cur_y       <= cur_y_next;
        minor_accum <= minor_accum_next;
        minor_bound <= minor_bound_next;
      end
    end
  end

  // Pixel attributes: dash flag, byte address, bit position, page check.
  assign px  = done ? end_x : cur_x;
  assign py  = done ? end_y : cur_y;
  assign sum = (x_backward == y_backward) ? px + py : px - py;
  assign row_offset = 27'(py) * 27'($signed({1'b0, bytes_per_line}));
  assign addr = 32'(row_offset) + 32'(px >>> 3);

  always_comb begin
    word              = '0;
    word.pixel_x      = px;
    word.pixel_y      = py;
    word.plot         = |(sum & pattern_mask);
    word.byte_address = addr;
    word.bit_position = ~px[2:0];
    word.on_page      = addr < dlr_pkg::PAGE_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      m_tdata <= word;
      m_tlast <= done;
    end
  end

  // Checks on the walk state.
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> busy && minor_accum == '0 && minor_bound == '0)
    else $error("start did not load an active line");

  a_accum_nonneg: assert property (@(posedge clk) disable iff (rst)
    !minor_accum[AW-1] && !minor_bound[AW-1])
    else $error("error accumulator went negative");

  a_major_moves: assert property (@(posedge clk) disable iff (rst)
    (step_fire && !done && x_major) |=> cur_x != $past(cur_x))
    else $error("major axis did not advance");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step_fire && done) |=> !busy && m_tvalid && m_tlast)
    else $error("end point did not close the line");

endmodule
